/* src/spp_pkg.sv */
// Shared types and constants for the sample packer ping-pong writer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package spp_pkg;

   localparam int SAMPLE_W             = 10;
   localparam int WORD_W               = 32;
   localparam int INDEX_W              = 7;
   localparam int COUNT_W              = 10;
   localparam int WORDS_PER_BUFFER_DEF = 128;
   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;

   localparam logic [COUNT_W-1:0] MAX_BLOCKS_RESET = COUNT_W'(10);
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_MAX  = COUNT_W'(1023);

   // Command codes on the request channel
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   // Register index, taken from the word address
   localparam logic REG_MAX_BLOCKS = 1'b0;

   // Position of the next sample inside its group of three
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_word;
      logic               buffer_half;
      logic [INDEX_W-1:0] word_index;
      logic               block_ready;
      logic [COUNT_W-1:0] block_count;
      logic               recording_done;
   } spp_result_type;

endpackage

`default_nettype wire

/* src/spp_packer.sv */
// Sample grouping, word packing and buffer/block bookkeeping.
// Depends on spp_pkg for widths, codes and the result struct.
`default_nettype none

module spp_packer #(
   parameter int WORDS_PER_BUFFER = spp_pkg::WORDS_PER_BUFFER_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic                              cmd,
   input  wire logic [spp_pkg::SAMPLE_W-1:0]      sample,
   input  wire logic [spp_pkg::COUNT_W-1:0]       max_blocks,
   output      logic                              emit,
   output      spp_pkg::spp_result_type           result
);

   localparam int CW = (WORDS_PER_BUFFER > 1) ? $clog2(WORDS_PER_BUFFER) : 1;
   localparam logic [CW-1:0] LAST_WORD = CW'(WORDS_PER_BUFFER - 1);

   logic [spp_pkg::SAMPLE_W-1:0] held0_ff, held0_in;
   logic [spp_pkg::SAMPLE_W-1:0] held1_ff, held1_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [CW-1:0]                word_cnt_ff, word_cnt_in;
   logic                         half_ff, half_in;
   logic [spp_pkg::COUNT_W-1:0]  blocks_ff, blocks_in;
   logic                         recording_ff, recording_in;
   logic [CW+spp_pkg::INDEX_W-1:0] word_cnt_ext;

   assign word_cnt_ext = {{spp_pkg::INDEX_W{1'b0}}, word_cnt_ff};

   always_comb begin
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      phase_in     = phase_ff;
      word_cnt_in  = word_cnt_ff;
      half_in      = half_ff;
      blocks_in    = blocks_ff;
      recording_in = recording_ff;
      emit         = 1'b0;

      result.packed_word    = {held0_ff, held1_ff, sample, 2'b00};
      result.buffer_half    = half_ff;
      result.word_index     = word_cnt_ext[spp_pkg::INDEX_W-1:0];
      result.block_ready    = 1'b0;
      result.block_count    = blocks_ff;
      result.recording_done = 1'b0;

      if (accept) begin
         if (cmd == spp_pkg::CMD_START) begin
            held0_in     = '0;
            held1_in     = '0;
            phase_in     = spp_pkg::PHASE_FIRST;
            word_cnt_in  = '0;
            half_in      = 1'b0;
            blocks_in    = '0;
            recording_in = 1'b1;
         end else if (recording_ff) begin
            case (phase_ff)
               spp_pkg::PHASE_FIRST: begin
                  held0_in = sample;
                  phase_in = spp_pkg::PHASE_SECOND;
               end
               spp_pkg::PHASE_SECOND: begin
                  held1_in = sample;
                  phase_in = spp_pkg::PHASE_THIRD;
               end
               default: begin
                  phase_in = spp_pkg::PHASE_FIRST;
                  emit     = 1'b1;
                  if (word_cnt_ff >= LAST_WORD) begin
                     word_cnt_in = '0;
                     half_in     = ~half_ff;
                     if (blocks_ff < spp_pkg::BLOCK_COUNT_MAX) begin
                        blocks_in = blocks_ff + spp_pkg::COUNT_W'(1);
                     end
                     result.block_ready = 1'b1;
                     result.block_count = blocks_in;
                     if (blocks_in >= max_blocks) begin
                        recording_in          = 1'b0;
                        result.recording_done = 1'b1;
                     end
                  end else begin
                     word_cnt_in = word_cnt_ff + CW'(1);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held0_ff     <= '0;
         held1_ff     <= '0;
         phase_ff     <= spp_pkg::PHASE_FIRST;
         word_cnt_ff  <= '0;
         half_ff      <= 1'b0;
         blocks_ff    <= '0;
         recording_ff <= 1'b0;
      end else begin
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         phase_ff     <= phase_in;
         word_cnt_ff  <= word_cnt_in;
         half_ff      <= half_in;
         blocks_ff    <= blocks_in;
         recording_ff <= recording_in;
      end
   end

endmodule

`default_nettype wire

/* src/spp_out_reg.sv */
// Result register between the packer and the response channel.
// Depends on spp_pkg for the result struct.
`default_nettype none

module spp_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire spp_pkg::spp_result_type load_data,
   output      logic                    space,
   output      logic                    out_valid,
   input  wire logic                    out_ready,
   output      spp_pkg::spp_result_type out_data
);

   logic                    valid_ff, valid_in;
   spp_pkg::spp_result_type data_ff, data_in;

   // Room when empty or when the held word leaves this cycle
   assign space = ~valid_ff | out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (space) begin
         valid_in = load;
         if (load) begin
            data_in = load_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* src/sample_packer_ping_pong_writer_top.sv */
// A word appears on rsp_ in the cycle after the third sample of its group is taken.
// Throughput: one request word per cycle; the single result register refills in the
// same cycle it drains, so req_ready only drops while a held result is stalled.
// Reset (synchronous, active high): not recording, all counters and halves cleared,
// max_blocks back to 10, result register empty.
`default_nettype none

module sample_packer_ping_pong_writer_top #(
   parameter int WORDS_PER_BUFFER = spp_pkg::WORDS_PER_BUFFER_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_cmd,
   input  wire logic [spp_pkg::SAMPLE_W-1:0]      req_sample,
   // response channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [spp_pkg::WORD_W-1:0]        rsp_packed_word,
   output      logic                              rsp_buffer_half,
   output      logic [spp_pkg::INDEX_W-1:0]       rsp_word_index,
   output      logic                              rsp_block_ready,
   output      logic [spp_pkg::COUNT_W-1:0]       rsp_block_count,
   output      logic                              rsp_recording_done,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [spp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [spp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [spp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                              csr_pready
);

   logic                         accept;
   logic                         emit;
   logic                         space;
   logic                         reg_index;
   logic [spp_pkg::COUNT_W-1:0]  max_blocks_ff, max_blocks_in;
   spp_pkg::spp_result_type      result;
   spp_pkg::spp_result_type      rsp_data;

   // ---------------------------------------------------------------
   // Register port: one register, max_blocks, at byte address 0.
   // Word address is paddr[2]; the low byte-lane bits are ignored.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      max_blocks_in = max_blocks_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_index == spp_pkg::REG_MAX_BLOCKS) begin
         max_blocks_in = csr_pwdata[spp_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_blocks_ff <= spp_pkg::MAX_BLOCKS_RESET;
      end else begin
         max_blocks_ff <= max_blocks_in;
      end
   end

   // Read back the limit, zero for addresses past the register list
   always_comb begin
      csr_prdata = '0;
      if (reg_index == spp_pkg::REG_MAX_BLOCKS) begin
         csr_prdata = {{(spp_pkg::CSR_DATA_W - spp_pkg::COUNT_W){1'b0}}, max_blocks_ff};
      end
   end

   // ---------------------------------------------------------------
   // Take a request whenever the result register has room; every
   // request word updates state, also yields a result, or (a sample while idle) is dropped.
   // ---------------------------------------------------------------
   assign req_ready = space;
   assign accept    = req_valid & req_ready;

   spp_packer #(
      .WORDS_PER_BUFFER (WORDS_PER_BUFFER)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .sample     (req_sample),
      .max_blocks (max_blocks_ff),
      .emit       (emit),
      .result     (result)
   );

   // Hold the finished word until the response side takes it
   spp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_packed_word    = rsp_data.packed_word;
   assign rsp_buffer_half    = rsp_data.buffer_half;
   assign rsp_word_index     = rsp_data.word_index;
   assign rsp_block_ready    = rsp_data.block_ready;
   assign rsp_block_count    = rsp_data.block_count;
   assign rsp_recording_done = rsp_data.recording_done;

endmodule

`default_nettype wire

/* src/spp_checker.sv */
// Port-level checks for the sample packer ping-pong writer, bound to its top level.
// Depends on spp_pkg for field widths.
`default_nettype none

module spp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [spp_pkg::WORD_W-1:0]     rsp_packed_word,
   input wire logic                           rsp_block_ready,
   input wire logic                           rsp_recording_done,
   input wire logic                           csr_pready
);

   // Completion only comes with the word that closes a block
   a_done_ends_block : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recording_done |-> rsp_block_ready)
      else $error("recording_done without block_ready");

   // Packing leaves the two low bits clear
   a_pad_bits_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packed_word[1:0] == 2'b00)
      else $error("packed word pad bits not zero");

   // Nothing is offered right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled word stays offered and unchanged
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_word))
      else $error("stalled result changed");

   a_pready_high : assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind sample_packer_ping_pong_writer_top spp_checker u_spp_checker (.*);

`default_nettype wire
